// ===== hdl/gated_pulse_peak_finder_top_assert.svh =====
// assertion macros shared by the peak finder rtl
`ifndef GATED_PULSE_PEAK_FINDER_TOP_ASSERT_SVH
`define GATED_PULSE_PEAK_FINDER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define GPPF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gppf assertion failed");

// next-cycle implication, disabled while reset is held
`define GPPF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gppf assertion failed");

`endif

// ===== hdl/gppf_pkg.sv =====
// shared constants for the gated pulse peak finder
`default_nettype none

package gppf_pkg;

  // field widths
  localparam int unsigned LenW    = 21;
  localparam int unsigned OffW    = 20;
  localparam int unsigned WidW    = 11;
  localparam int unsigned PerW    = 21;
  localparam int unsigned IdxTrW  = 20;
  localparam int unsigned SampleW = 32;
  localparam int unsigned CfgW    = 21;
  localparam int unsigned CfgIdxW = 2;

  // longest trace, also the saturation point of window starts
  localparam logic [LenW-1:0] TraceMax = 21'd1048576;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_TRACE_LENGTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_OFFSET     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_WIDTH     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CANDIDATE_PERIOD = 2'd3;

  // register reset values
  localparam logic [LenW-1:0] RstTraceLength     = 21'd1024;
  localparam logic [OffW-1:0] RstStartOffset     = 20'd0;
  localparam logic [WidW-1:0] RstWindowWidth     = 11'd16;
  localparam logic [PerW-1:0] RstCandidatePeriod = 21'd64;

  // sequencer states
  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] ST_IDLE = 3'd0;
  localparam logic [StW-1:0] ST_EVAL = 3'd1;
  localparam logic [StW-1:0] ST_SCAN = 3'd2;
  localparam logic [StW-1:0] ST_END  = 3'd3;

endpackage

`default_nettype wire

// ===== hdl/gppf_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module gppf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gated_pulse_peak_finder_top.sv =====
// Gated pulse peak finder: picks the first tag-free window of a trace and
// reports its peak absolute sample.
//
// Samples enter on the in channel (in_valid_i / in_stall_o) with a tag bit.
// Each trace of trace_length samples returns exactly one result on the out
// channel (out_valid_o / out_stall_i): position, amplitude and found.
// An ordinary sample is captured, then written to the ring and window-tested.
// The sample that closes the first tag-free window starts a scan of the
// window ring through one compare unit and one ram read port, one entry per
// cycle. The last sample of a trace passes through an end state that loads
// the output register and waits there if the output slot is still occupied
// by an earlier result.
// A result held under out_stall_i does not block input; the next trace's
// samples keep flowing until its own last sample needs the output slot.
// Reset returns the config registers to their defaults and starts a fresh
// trace; the ring needs no clearing since only entries written in the
// current trace are ever read.
// Config writes are meant for idle periods and take effect at once.
`default_nettype none

module gated_pulse_peak_finder_top
  import gppf_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic               tagged_req_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [LenW-1:0]    position_o,
  output logic      [SampleW-1:0] amplitude_o,
  output logic                    found_o
);

  // largest usable window and derived widths
  localparam int unsigned WinCap = (WINDOW_MAX < 2047) ? WINDOW_MAX : 2047;
  localparam int unsigned KW     = $clog2(WinCap + 1);
  localparam int unsigned IdxW   = (WinCap > 1) ? $clog2(WinCap) : 1;
  localparam int unsigned AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [AW-1:0] PtrLast = AW'(WINDOW_MAX - 1);
  localparam logic [AW:0]   RingDepth = (AW + 1)'(WINDOW_MAX);

  localparam logic [32:0]        SampleMaskW = (33'd1 << SAMPLE_BITS) - 33'd1;
  localparam logic [SampleW-1:0] SampleMask  = SampleMaskW[SampleW-1:0];

  // config registers
  logic [LenW-1:0] trace_length_q;
  logic [OffW-1:0] start_offset_q;
  logic [WidW-1:0] window_width_q;
  logic [PerW-1:0] candidate_period_q;

  // sequencer and trace state
  logic [StW-1:0]    state_q, state_d;
  logic [SampleW-1:0] s_mag_q, s_mag_d;
  logic              s_tag_q;
  logic [IdxTrW-1:0] idx_q, idx_d;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [LenW-1:0]   nws_q, nws_d;
  logic [IdxTrW-1:0] lti_q, lti_d;
  logic              ltv_q, ltv_d;
  logic              done_q, done_d;
  logic [SampleW-1:0] peak_amp_q, peak_amp_d;
  logic [IdxW-1:0]   peak_idx_q, peak_idx_d;

  // scan unit
  logic [KW-1:0]     issue_k_q, issue_k_d;
  logic [KW-1:0]     data_k_q, data_k_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     scan_ptr_q, scan_ptr_d;
  logic              ram_re;
  logic [SampleW-1:0] ram_rdata;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [LenW-1:0]   out_pos_q, out_pos_d;
  logic [SampleW-1:0] out_amp_q, out_amp_d;
  logic              out_found_q, out_found_d;

  // effective register values
  logic [LenW-1:0] len_eff;
  logic [KW-1:0]   w_eff;
  logic [PerW-1:0] period_eff;
  logic [KW-1:0]   last_k;
  logic [AW-1:0]   w_m1;
  logic [AW:0]     start_diff;
  logic [AW-1:0]   scan_start;

  // window test terms
  logic [LenW:0]   nws_end;
  logic [LenW:0]   nws_next;
  logic            win_hit;
  logic            win_tagged;
  logic            trace_end;
  logic            in_accept;
  logic            out_free;
  logic [SampleW-1:0] mag_raw;
  logic [SampleW-1:0] mag_val;

  always_comb begin
    if (trace_length_q == '0) begin
      len_eff = LenW'(1);
    end else if (trace_length_q > TraceMax) begin
      len_eff = TraceMax;
    end else begin
      len_eff = trace_length_q;
    end
    if (window_width_q == '0) begin
      w_eff = KW'(1);
    end else if (window_width_q > WidW'(WinCap)) begin
      w_eff = KW'(WinCap);
    end else begin
      w_eff = KW'(window_width_q);
    end
    period_eff = (candidate_period_q == '0) ? PerW'(1) : candidate_period_q;
  end

  assign last_k = w_eff - KW'(1);
  assign w_m1   = AW'(last_k);

  // ring slot of the window's first sample, wrapped around the ring
  assign start_diff = {1'b0, wr_ptr_q} - {1'b0, w_m1};
  assign scan_start = (wr_ptr_q < w_m1) ? AW'(start_diff + RingDepth) : start_diff[AW-1:0];

  assign nws_end    = (LenW + 1)'(nws_q) + (LenW + 1)'(w_eff) - (LenW + 1)'(1);
  assign nws_next   = (LenW + 1)'(nws_q) + (LenW + 1)'(period_eff);
  assign win_hit    = !done_q && (nws_end < (LenW + 1)'(len_eff))
                      && ((LenW + 1)'(idx_q) == nws_end);
  assign win_tagged = s_tag_q || (ltv_q && ((LenW)'(lti_q) >= nws_q));
  assign trace_end  = ((LenW)'(idx_q) + LenW'(1)) >= len_eff;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // absolute value within the low sample bits
  assign mag_raw = sample_i & SampleMask;
  assign mag_val = mag_raw[SAMPLE_BITS-1] ? (((~mag_raw) + SampleW'(1)) & SampleMask)
                                          : mag_raw;

  assign in_stall_o = (state_q != ST_IDLE);
  assign ram_re     = (state_q == ST_SCAN) && (issue_k_q < w_eff);

  // sequencer
  always_comb begin
    state_d     = state_q;
    s_mag_d     = s_mag_q;
    idx_d       = idx_q;
    wr_ptr_d    = wr_ptr_q;
    nws_d       = nws_q;
    lti_d       = lti_q;
    ltv_d       = ltv_q;
    done_d      = done_q;
    peak_amp_d  = peak_amp_q;
    peak_idx_d  = peak_idx_q;
    issue_k_d   = issue_k_q;
    data_k_d    = data_k_q;
    rd_vld_d    = 1'b0;
    scan_ptr_d  = scan_ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pos_d   = out_pos_q;
    out_amp_d   = out_amp_q;
    out_found_d = out_found_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          s_mag_d = mag_val;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        // ring write happens this cycle at wr_ptr_q
        wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + AW'(1);
        if (s_tag_q) begin
          lti_d = idx_q;
          ltv_d = 1'b1;
        end
        if (win_hit && win_tagged) begin
          nws_d = (nws_next > (LenW + 1)'(TraceMax)) ? TraceMax : nws_next[LenW-1:0];
        end
        if (win_hit && !win_tagged) begin
          done_d     = 1'b1;
          peak_amp_d = '0;
          peak_idx_d = '0;
          issue_k_d  = '0;
          data_k_d   = '0;
          scan_ptr_d = scan_start;
          state_d    = ST_SCAN;
        end else if (trace_end) begin
          state_d = ST_END;
        end else begin
          idx_d   = idx_q + IdxTrW'(1);
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // issue one ring read per cycle
        if (ram_re) begin
          issue_k_d  = issue_k_q + KW'(1);
          scan_ptr_d = (scan_ptr_q == PtrLast) ? '0 : scan_ptr_q + AW'(1);
          rd_vld_d   = 1'b1;
        end
        // compare the returning entry, first maximum wins
        if (rd_vld_q) begin
          if (ram_rdata > peak_amp_q) begin
            peak_amp_d = ram_rdata;
            peak_idx_d = data_k_q[IdxW-1:0];
          end
          data_k_d = data_k_q + KW'(1);
          if (data_k_q == last_k) begin
            if (trace_end) begin
              state_d = ST_END;
            end else begin
              idx_d   = idx_q + IdxTrW'(1);
              state_d = ST_IDLE;
            end
          end
        end
      end

      ST_END: begin
        // load the result once the output slot is free, then open a new trace
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = done_q;
          out_pos_d   = done_q ? (LenW'(start_offset_q) + LenW'(peak_idx_q) + LenW'(1)) : '0;
          out_amp_d   = done_q ? peak_amp_q : '0;
          idx_d       = '0;
          wr_ptr_d    = '0;
          nws_d       = LenW'(start_offset_q);
          lti_d       = '0;
          ltv_d       = 1'b0;
          done_d      = 1'b0;
          peak_amp_d  = '0;
          peak_idx_d  = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_length_q     <= RstTraceLength;
      start_offset_q     <= RstStartOffset;
      window_width_q     <= RstWindowWidth;
      candidate_period_q <= RstCandidatePeriod;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRACE_LENGTH:     trace_length_q     <= cfg_data_i[LenW-1:0];
        CFG_START_OFFSET:     start_offset_q     <= cfg_data_i[OffW-1:0];
        CFG_WINDOW_WIDTH:     window_width_q     <= cfg_data_i[WidW-1:0];
        CFG_CANDIDATE_PERIOD: candidate_period_q <= cfg_data_i[PerW-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      wr_ptr_q    <= '0;
      nws_q       <= LenW'(RstStartOffset);
      lti_q       <= '0;
      ltv_q       <= 1'b0;
      done_q      <= 1'b0;
      peak_amp_q  <= '0;
      peak_idx_q  <= '0;
      issue_k_q   <= '0;
      data_k_q    <= '0;
      rd_vld_q    <= 1'b0;
      scan_ptr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      wr_ptr_q    <= wr_ptr_d;
      nws_q       <= nws_d;
      lti_q       <= lti_d;
      ltv_q       <= ltv_d;
      done_q      <= done_d;
      peak_amp_q  <= peak_amp_d;
      peak_idx_q  <= peak_idx_d;
      issue_k_q   <= issue_k_d;
      data_k_q    <= data_k_d;
      rd_vld_q    <= rd_vld_d;
      scan_ptr_q  <= scan_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_mag_q     <= s_mag_d;
    out_pos_q   <= out_pos_d;
    out_amp_q   <= out_amp_d;
    out_found_q <= out_found_d;
    if (in_accept) begin
      s_tag_q <= tagged_req_i;
    end
  end

  // magnitude ring
  gppf_ram #(
    .WIDTH (SampleW),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_EVAL),
    .waddr_i (wr_ptr_q),
    .wdata_i (s_mag_q),
    .re_i    (ram_re),
    .raddr_i (scan_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign amplitude_o = out_amp_q;
  assign found_o     = out_found_q;

  // checks
`include "gated_pulse_peak_finder_top_assert.svh"

  `GPPF_ASSERT_NOW(a_rd_only_in_scan, clk_i, rst_ni, rd_vld_q, state_q == ST_SCAN)
  `GPPF_ASSERT_NOW(a_issue_bounded, clk_i, rst_ni, state_q == ST_SCAN, issue_k_q <= w_eff)
  `GPPF_ASSERT_NOW(a_scan_only_when_done, clk_i, rst_ni, state_q == ST_SCAN, done_q)
  `GPPF_ASSERT_NOW(a_empty_result_zero, clk_i, rst_ni, out_valid_o && !found_o,
                   position_o == '0 && amplitude_o == '0)
  `GPPF_ASSERT_NEXT(a_accept_to_eval, clk_i, rst_ni, in_accept, state_q == ST_EVAL)

endmodule

`default_nettype wire
